@@ rtl/csg_pkg.sv @@
// Shared types, constants and codes of the CRT scanline glow filter.
// Used by csg_div and crt_scanline_glow_filter_core; depends on nothing.
package csg_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int RING_ROWS  = 8;
   localparam int COL_W      = 11;
   localparam int ROW_W      = 12;
   localparam int SIZE_W     = 12;
   localparam int RING_W     = 3;
   localparam int ADDR_W     = RING_W + COL_W;
   localparam int MEM_DEPTH  = RING_ROWS * MAX_WIDTH;
   localparam int PIX_W      = 24;
   localparam int SUM_W      = 13;
   localparam int CNT_W      = 5;
   localparam int POS_W      = 24;
   localparam int GAIN_W     = 9;
   localparam int TAPS       = 26;

   typedef logic [2:0][SUM_W-1:0] sum3_type;
   typedef logic [2:0][7:0]       chan3_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_SCANLINE_KEEP = 3'd2,
      CSR_FLICKER_GAIN  = 3'd3,
      CSR_STRIPES_ON    = 3'd4,
      CSR_STRIPES_SHIFT = 3'd5,
      CSR_GLOW_GAIN     = 3'd6
   } csr_index_type;

   // Sequencer states of the core.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS,
      ST_TOT,
      ST_WR,
      ST_RD,
      ST_DRAIN,
      ST_LOAD,
      ST_DIV,
      ST_SCAN,
      ST_STRIPE,
      ST_FLICK,
      ST_GLOW
   } state_type;

endpackage

@@ rtl/crt_scanline_glow_filter_core.sv @@
// Top level of the CRT scanline glow filter: sequencer, line store and pixel math.
// Depends on csg_pkg, csg_ram and csg_div.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_type, req_in_blue/green/red
//   rsp      out        rsp_valid/rsp_ready    rsp_out_blue/green/red, rsp_frame_end
//   csr      in         csr_we                 csr_index, csr_wdata
//
// An item that only fills the store passes the position, total and write steps; one
// that yields a result goes on to 26 store reads (center pixel plus 5x5 window)
// through the single read port, a wait for the last read to land, the divider load,
// the divider's 13 steps and its done flag, and four single-multiply steps.
// Reset is synchronous; the line store is not cleared.
// A finished result waits in the output register while the next item is accepted;
// the sequencer only stalls in its last step if the previous result is still untaken.
module crt_scanline_glow_filter_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [7:0]                  req_in_blue,
   input  logic [7:0]                  req_in_green,
   input  logic [7:0]                  req_in_red,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_blue,
   output logic [7:0]                  rsp_out_green,
   output logic [7:0]                  rsp_out_red,
   output logic                        rsp_frame_end,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [csg_pkg::SIZE_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [csg_pkg::SIZE_W-1:0] fw_ff, fh_ff;
   logic [csg_pkg::GAIN_W-1:0] keep_ff, fg_ff, gg_ff;
   logic                       son_ff, sshift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= 12'd640;
         fh_ff     <= 12'd480;
         keep_ff   <= 9'd179;
         fg_ff     <= 9'd256;
         son_ff    <= 1'b0;
         sshift_ff <= 1'b0;
         gg_ff     <= 9'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            csg_pkg::CSR_FRAME_WIDTH:   fw_ff     <= csr_wdata;
            csg_pkg::CSR_FRAME_HEIGHT:  fh_ff     <= csr_wdata;
            csg_pkg::CSR_SCANLINE_KEEP: keep_ff   <= csr_wdata[csg_pkg::GAIN_W-1:0];
            csg_pkg::CSR_FLICKER_GAIN:  fg_ff     <= csr_wdata[csg_pkg::GAIN_W-1:0];
            csg_pkg::CSR_STRIPES_ON:    son_ff    <= csr_wdata[0];
            csg_pkg::CSR_STRIPES_SHIFT: sshift_ff <= csr_wdata[0];
            csg_pkg::CSR_GLOW_GAIN:     gg_ff     <= csr_wdata[csg_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size and scanline factor.
   logic [csg_pkg::SIZE_W-1:0] w, h;
   logic [8:0]                 keep;

   always_comb begin
      w = fw_ff;
      if (fw_ff == '0) w = 12'd1;
      else if (fw_ff > 12'(csg_pkg::MAX_WIDTH)) w = 12'(csg_pkg::MAX_WIDTH);
      h = fh_ff;
      if (fh_ff == '0) h = 12'd1;
      else if (fh_ff > 12'(csg_pkg::MAX_HEIGHT)) h = 12'(csg_pkg::MAX_HEIGHT);
      keep = (keep_ff > 9'd256) ? 9'd256 : keep_ff;
   end

   // Sequencer and datapath registers.
   csg_pkg::state_type          state_ff, state_in;
   logic [csg_pkg::COL_W-1:0]   in_col_ff, out_col_ff;
   logic [csg_pkg::ROW_W-1:0]   in_row_ff, out_row_ff;
   logic [1:0]                  out_phase_ff;
   logic [csg_pkg::PIX_W-1:0]   pix_ff;
   logic [csg_pkg::POS_W-1:0]   pos_ff, total_ff;
   logic [4:0]                  tap_ff;
   logic [2:0]                  dy_ff, dx_ff;
   logic                        pend_ff, pend_orig_ff;
   csg_pkg::sum3_type           sum_ff;
   logic [csg_pkg::CNT_W-1:0]   cnt_ff;
   logic [csg_pkg::PIX_W-1:0]   orig_ff;
   csg_pkg::chan3_type          ch_ff, avg_ff;
   logic                        rsp_valid_ff;
   csg_pkg::chan3_type          rsp_ch_ff;
   logic                        rsp_end_ff;

   // Control decoded from the state.
   logic mem_we, rd_issue, div_start, commit, out_free, has_result, do_write;
   logic [csg_pkg::POS_W-1:0] delay;
   logic               div_done;
   csg_pkg::chan3_type div_q;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign delay      = csg_pkg::POS_W'({w, 1'b0}) + csg_pkg::POS_W'(2);
   assign do_write   = pos_ff < total_ff;
   assign has_result = pos_ff >= delay;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csg_pkg::ST_IDLE:   if (req_valid) state_in = csg_pkg::ST_POS;
         csg_pkg::ST_POS:    state_in = csg_pkg::ST_TOT;
         csg_pkg::ST_TOT:    state_in = csg_pkg::ST_WR;
         csg_pkg::ST_WR:     state_in = has_result ? csg_pkg::ST_RD : csg_pkg::ST_IDLE;
         csg_pkg::ST_RD:
            if (tap_ff == 5'(csg_pkg::TAPS - 1)) state_in = csg_pkg::ST_DRAIN;
         csg_pkg::ST_DRAIN:  state_in = csg_pkg::ST_LOAD;
         csg_pkg::ST_LOAD:   state_in = csg_pkg::ST_DIV;
         csg_pkg::ST_DIV:    if (div_done) state_in = csg_pkg::ST_SCAN;
         csg_pkg::ST_SCAN:   state_in = csg_pkg::ST_STRIPE;
         csg_pkg::ST_STRIPE: state_in = csg_pkg::ST_FLICK;
         csg_pkg::ST_FLICK:  state_in = csg_pkg::ST_GLOW;
         csg_pkg::ST_GLOW:   if (out_free) state_in = csg_pkg::ST_IDLE;
         default:            state_in = csg_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      rd_issue  = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         csg_pkg::ST_IDLE:  req_ready = 1'b1;
         csg_pkg::ST_WR:    mem_we = do_write;
         csg_pkg::ST_RD:    rd_issue = 1'b1;
         csg_pkg::ST_LOAD:  div_start = 1'b1;
         csg_pkg::ST_GLOW:  commit = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= csg_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // Window read address and frame-edge clipping for the current tap.
   logic [csg_pkg::ROW_W:0]    syw, sy;
   logic [csg_pkg::COL_W:0]    sxw, sx;
   logic                       tap_in_frame;
   logic [csg_pkg::ADDR_W-1:0] raddr, waddr;
   logic [csg_pkg::PIX_W-1:0]  rdata;

   always_comb begin
      syw = {1'b0, out_row_ff} + 13'(dy_ff);
      sxw = {1'b0, out_col_ff} + 12'(dx_ff);
      sy  = syw - 13'd2;
      sx  = sxw - 12'd2;
      tap_in_frame = (syw >= 13'd2) && (sy < {1'b0, h}) && (sxw >= 12'd2) && (sx < w);
      if (tap_ff == '0) raddr = {out_row_ff[csg_pkg::RING_W-1:0], out_col_ff};
      else              raddr = {sy[csg_pkg::RING_W-1:0], sx[csg_pkg::COL_W-1:0]};
      waddr = {in_row_ff[csg_pkg::RING_W-1:0], in_col_ff};
   end

   csg_ram #(.WIDTH(csg_pkg::PIX_W), .DEPTH(csg_pkg::MEM_DEPTH)) u_line_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (waddr),
      .wdata (pix_ff),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Neighbourhood average.
   csg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Counter updates: the next position along a row and down the frame.
   logic [csg_pkg::COL_W:0]    in_col_inc, out_col_inc;
   logic [csg_pkg::ROW_W:0]    out_row_inc;
   logic                       last;
   logic [1:0]                 phase;
   logic [1:0]                 kept;

   always_comb begin
      in_col_inc  = {1'b0, in_col_ff} + 12'd1;
      out_col_inc = {1'b0, out_col_ff} + 12'd1;
      out_row_inc = {1'b0, out_row_ff} + 13'd1;
      last  = (out_row_inc >= {1'b0, h}) && (out_col_inc >= w);
      phase = out_phase_ff + {1'b0, sshift_ff};
      if (phase == 2'd3) phase = 2'd0;
      // Lanes are blue, green, red; phase 0 keeps red, 1 green, 2 blue.
      case (phase)
         2'd0:    kept = 2'd2;
         2'd1:    kept = 2'd1;
         default: kept = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_phase_ff <= '0;
      end else if (state_ff == csg_pkg::ST_WR && !has_result) begin
         if (in_col_inc >= w) begin
            in_col_ff <= '0;
            in_row_ff <= in_row_ff + 12'd1;
         end else begin
            in_col_ff <= in_col_inc[csg_pkg::COL_W-1:0];
         end
      end else if (commit) begin
         if (last) begin
            in_col_ff    <= '0;
            in_row_ff    <= '0;
            out_col_ff   <= '0;
            out_row_ff   <= '0;
            out_phase_ff <= '0;
         end else begin
            if (out_col_inc >= w) begin
               out_col_ff   <= '0;
               out_row_ff   <= out_row_inc[csg_pkg::ROW_W-1:0];
               out_phase_ff <= '0;
            end else begin
               out_col_ff   <= out_col_inc[csg_pkg::COL_W-1:0];
               out_phase_ff <= (out_phase_ff == 2'd2) ? 2'd0 : out_phase_ff + 2'd1;
            end
            if (in_col_inc >= w) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 12'd1;
            end else begin
               in_col_ff <= in_col_inc[csg_pkg::COL_W-1:0];
            end
         end
      end
   end

   // Item capture and frame position arithmetic.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pix_ff <= req_type ? '0 : {req_in_red, req_in_green, req_in_blue};
      end
      if (state_ff == csg_pkg::ST_POS) begin
         pos_ff <= csg_pkg::POS_W'(in_row_ff) * csg_pkg::POS_W'(w)
                   + csg_pkg::POS_W'(in_col_ff);
      end
      if (state_ff == csg_pkg::ST_TOT) begin
         total_ff <= csg_pkg::POS_W'(w) * csg_pkg::POS_W'(h);
      end
   end

   // Read sequencing: tap 0 is the center pixel, taps 1 to 25 the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= rd_issue && ((tap_ff == '0) || tap_in_frame);
      end
      pend_orig_ff <= (tap_ff == '0);
      if (state_ff == csg_pkg::ST_WR) begin
         tap_ff <= '0;
         dy_ff  <= '0;
         dx_ff  <= '0;
      end else if (rd_issue) begin
         tap_ff <= tap_ff + 5'd1;
         if (tap_ff != '0) begin
            if (dx_ff == 3'd4) begin
               dx_ff <= '0;
               dy_ff <= dy_ff + 3'd1;
            end else begin
               dx_ff <= dx_ff + 3'd1;
            end
         end
      end
   end

   // Accumulate the window and keep the center pixel.
   always_ff @(posedge clock) begin
      if (state_ff == csg_pkg::ST_WR) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (pend_ff) begin
         if (pend_orig_ff) begin
            orig_ff <= rdata;
         end else begin
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + csg_pkg::SUM_W'(rdata[8*i +: 8]);
            end
            cnt_ff <= cnt_ff + 5'd1;
         end
      end
   end

   // Per-channel steps: scanline, stripe, flicker, then glow into the output register.
   always_ff @(posedge clock) begin
      if (div_done) avg_ff <= div_q;
      for (int i = 0; i < 3; i++) begin
         case (state_ff)
            csg_pkg::ST_SCAN: begin
               if (out_row_ff[0]) ch_ff[i] <= 8'(({9'd0, orig_ff[8*i +: 8]} * keep) >> 8);
               else               ch_ff[i] <= orig_ff[8*i +: 8];
            end
            csg_pkg::ST_STRIPE: begin
               if (son_ff && (2'(i) != kept)) ch_ff[i] <= 8'(({9'd0, ch_ff[i]} * 17'd171) >> 9);
            end
            csg_pkg::ST_FLICK: begin
               logic [16:0] prod;
               prod = {9'd0, ch_ff[i]} * {8'd0, fg_ff};
               ch_ff[i] <= (prod[16:8] > 9'd255) ? 8'd255 : prod[15:8];
            end
            default: ;
         endcase
      end
   end

   logic [2:0][16:0] glow_prod;
   logic [2:0][9:0]  glow_sum;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         glow_prod[i] = {8'd0, gg_ff} * {9'd0, avg_ff[i]};
         glow_sum[i]  = {2'b0, ch_ff[i]} + {1'b0, glow_prod[i][16:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (commit) begin
         for (int i = 0; i < 3; i++) begin
            rsp_ch_ff[i] <= (glow_sum[i] > 10'd255) ? 8'd255 : glow_sum[i][7:0];
         end
         rsp_end_ff <= last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_blue  = rsp_ch_ff[0];
   assign rsp_out_green = rsp_ch_ff[1];
   assign rsp_out_red   = rsp_ch_ff[2];
   assign rsp_frame_end = rsp_end_ff;

   // The store is never written and read in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !rd_issue)
      else $error("line store write overlaps a window read");

   // The divider finishes only while the sequencer waits for it.
   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == csg_pkg::ST_DIV))
      else $error("divider result outside its wait state");

   // An accepted item always starts at the position step.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == csg_pkg::ST_POS))
      else $error("accepted item did not start the sequence");

   // A result is never overwritten while it waits.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

endmodule

@@ rtl/csg_ram.sv @@
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module csg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/csg_div.sv @@
// Three-lane restoring divider: neighbourhood sums divided by the pixel count.
// Depends on csg_pkg. One quotient bit per cycle, all lanes share the divisor.
module csg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  csg_pkg::sum3_type               dividend,
   input  logic [csg_pkg::CNT_W-1:0]       divisor,
   output logic                            done,
   output csg_pkg::chan3_type              quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [3:0]                       step_ff, step_in;
   logic [csg_pkg::CNT_W-1:0]        div_ff, div_in;
   logic [2:0][csg_pkg::CNT_W-1:0]   rem_ff, rem_in;
   csg_pkg::sum3_type                q_ff, q_in;

   // One restoring step per lane per cycle.
   always_comb begin
      logic [csg_pkg::CNT_W:0] trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         div_in  = divisor;
         rem_in  = '0;
         q_in    = dividend;
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            trial = {rem_ff[i], q_ff[i][csg_pkg::SUM_W-1]};
            if (trial >= {1'b0, div_ff}) begin
               rem_in[i] = csg_pkg::CNT_W'(trial - {1'b0, div_ff});
               q_in[i]   = {q_ff[i][csg_pkg::SUM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[csg_pkg::CNT_W-1:0];
               q_in[i]   = {q_ff[i][csg_pkg::SUM_W-2:0], 1'b0};
            end
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(csg_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
   end

   // An empty neighbourhood gives a zero average.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quotient[i] = (div_ff == '0) ? 8'd0 : q_ff[i][7:0];
      end
   end

   assign done = done_ff;

endmodule

@@ dv/crt_scanline_glow_filter_core_test.sv @@
// Self-checking testbench of the CRT scanline glow filter core.
// Depends on csg_pkg and crt_scanline_glow_filter_core; holds its own pixel predictor.
module crt_scanline_glow_filter_core_test;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_end;
   } glow_pixel_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_type;
   logic [7:0]                  req_in_blue;
   logic [7:0]                  req_in_green;
   logic [7:0]                  req_in_red;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [7:0]                  rsp_out_blue;
   logic [7:0]                  rsp_out_green;
   logic [7:0]                  rsp_out_red;
   logic                        rsp_frame_end;
   logic                        csr_we;
   logic [2:0]                  csr_index;
   logic [csg_pkg::SIZE_W-1:0]  csr_wdata;

   // Predictor state: its own copy of the line ring, counters and registers.
   logic [23:0]         ring_pixels [0:csg_pkg::MEM_DEPTH-1];
   int unsigned         col_in, row_in, col_out, row_out;
   int unsigned         width_reg, height_reg, keep_reg, flicker_reg;
   int unsigned         stripe_en_reg, stripe_shift_reg, glow_reg;

   glow_pixel_type      pending_pixels [$];
   int                  mismatches;
   int                  items_sent;
   bit                  calm;

   crt_scanline_glow_filter_core dut (.*);

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic int unsigned clip255(input int unsigned v);
      return (v > 255) ? 255 : v;
   endfunction

   // Computes the filtered pixel, if any, that one accepted item releases.
   function automatic bit glow_filter_step(input bit is_pad, input logic [7:0] b,
         input logic [7:0] g, input logic [7:0] r, output glow_pixel_type px_out);
      int unsigned w, h, delay, pos, total, keep, cnt, phase, kept, avg, v;
      int unsigned sums [3];
      int unsigned chans [3];
      logic [23:0] orig, nb;
      int sy, sx;
      bit last;
      w = eff_dim(width_reg, csg_pkg::MAX_WIDTH);
      h = eff_dim(height_reg, csg_pkg::MAX_HEIGHT);
      delay = 2 * w + 2;
      pos = row_in * w + col_in;
      total = w * h;
      px_out = '0;
      if (pos < total && col_in < csg_pkg::MAX_WIDTH)
         ring_pixels[(row_in % csg_pkg::RING_ROWS) * csg_pkg::MAX_WIDTH + col_in] =
            is_pad ? 24'h0 : {r, g, b};
      if (pos < delay) begin
         col_in++;
         if (col_in >= w) begin
            col_in = 0;
            row_in++;
         end
         return 1'b0;
      end
      // Neighborhood sums over the 5x5 window, clipped at the frame edges.
      sums = '{0, 0, 0};
      cnt = 0;
      for (int dy = -2; dy <= 2; dy++) begin
         sy = int'(row_out) + dy;
         if (sy < 0 || sy >= int'(h)) continue;
         for (int dx = -2; dx <= 2; dx++) begin
            sx = int'(col_out) + dx;
            if (sx < 0 || sx >= int'(w)) continue;
            nb = ring_pixels[(sy % csg_pkg::RING_ROWS) * csg_pkg::MAX_WIDTH + sx];
            for (int k = 0; k < 3; k++) sums[k] += nb[8*k +: 8];
            cnt++;
         end
      end
      orig = (col_out < csg_pkg::MAX_WIDTH)
             ? ring_pixels[(row_out % csg_pkg::RING_ROWS) * csg_pkg::MAX_WIDTH + col_out]
             : 24'h0;
      keep = (keep_reg > 256) ? 256 : keep_reg;
      for (int k = 0; k < 3; k++) begin
         chans[k] = orig[8*k +: 8];
         if (row_out[0]) chans[k] = (chans[k] * keep) >> 8;
      end
      // Phosphor stripes keep red, green or blue by column phase.
      if (stripe_en_reg != 0) begin
         phase = (col_out + stripe_shift_reg) % 3;
         kept = (phase == 0) ? 2 : ((phase == 1) ? 1 : 0);
         for (int k = 0; k < 3; k++)
            if (k != kept) chans[k] = chans[k] / 3;
      end
      for (int k = 0; k < 3; k++) begin
         v = clip255((chans[k] * flicker_reg) >> 8);
         avg = (cnt != 0) ? sums[k] / cnt : 0;
         chans[k] = clip255(v + ((glow_reg * avg) >> 8));
      end
      last = (row_out + 1 >= h) && (col_out + 1 >= w);
      px_out.blue = 8'(chans[0]);
      px_out.green = 8'(chans[1]);
      px_out.red = 8'(chans[2]);
      px_out.frame_end = last;
      if (last) begin
         col_in = 0;
         row_in = 0;
         col_out = 0;
         row_out = 0;
      end else begin
         col_out++;
         if (col_out >= w) begin
            col_out = 0;
            row_out++;
         end
         col_in++;
         if (col_in >= w) begin
            col_in = 0;
            row_in++;
         end
      end
      return 1'b1;
   endfunction

   // Receiver stalls in random bursts, none once the run is calm.
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Compares each accepted pixel with the oldest prediction.
   always @(posedge clock) begin
      glow_pixel_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_blue, rsp_out_green, rsp_out_red, rsp_frame_end};
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected pixel at %0t: b=%0d g=%0d r=%0d end=%0b", $realtime,
                        got.blue, got.green, got.red, got.frame_end);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch at %0t: expected b=%0d g=%0d r=%0d end=%0b,",
                            " got b=%0d g=%0d r=%0d end=%0b"},
                           $realtime, want.blue, want.green, want.red, want.frame_end,
                           got.blue, got.green, got.red, got.frame_end);
            end
         end
      end
   end

   // Sends one item and predicts its result once it is accepted.
   task automatic send_item(input bit is_pad, input logic [7:0] b, input logic [7:0] g,
         input logic [7:0] r);
      glow_pixel_type px;
      if (!calm && $urandom_range(4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= is_pad;
      req_in_blue <= b;
      req_in_green <= g;
      req_in_red <= r;
      do @(posedge clock); while (!req_ready);
      if (glow_filter_step(is_pad, b, g, r, px)) pending_pixels.push_back(px);
      items_sent++;
   endtask

   // Stops sending and waits until every predicted pixel has arrived.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Writes all registers while the block is idle.
   task automatic load_settings(input int unsigned w, input int unsigned h,
         input int unsigned keep, input int unsigned flick, input int unsigned son,
         input int unsigned sshift, input int unsigned glow);
      int unsigned vals [7];
      drain_pixels();
      repeat (100) @(posedge clock);
      vals = '{w, h, keep, flick, son, sshift, glow};
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i][csg_pkg::SIZE_W-1:0];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      width_reg = w & 12'hFFF;
      height_reg = h & 12'hFFF;
      keep_reg = keep & 9'h1FF;
      flicker_reg = flick & 9'h1FF;
      stripe_en_reg = son & 1;
      stripe_shift_reg = sshift & 1;
      glow_reg = glow & 9'h1FF;
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One whole frame plus its flush; pad_pct puts pads inside the frame,
   // flush_pct puts pixels into the flush, and hold_at pauses until drained.
   task automatic run_frame(input int pad_pct, input int flush_pct, input int hold_at);
      int unsigned w, h, n;
      bit pad;
      w = eff_dim(width_reg, csg_pkg::MAX_WIDTH);
      h = eff_dim(height_reg, csg_pkg::MAX_HEIGHT);
      n = w * h + 2 * w + 2;
      for (int unsigned i = 0; i < n; i++) begin
         if (i == hold_at) drain_pixels();
         if (i < w * h) pad = ($urandom_range(99) < pad_pct);
         else pad = !($urandom_range(99) < flush_pct);
         send_item(pad, pick_channel(), pick_channel(), pick_channel());
      end
   endtask

   // Small frames with extreme gains, stripes, pads in frame and pixels in flush.
   task automatic test_directed_frames();
      load_settings(3, 2, 256, 511, 1, 1, 256);
      run_frame(20, 30, -1);
      load_settings(0, 0, 0, 0, 0, 0, 0);
      run_frame(0, 50, -1);
   endtask

   // Scanline factor above one saturates; odd and even rows both appear.
   task automatic test_scanline_saturation();
      load_settings(5, 4, 511, 300, 1, 0, 128);
      run_frame(10, 10, 7);
   endtask

   // Degenerate frame shapes: a zero width or height acts as one.
   task automatic test_size_extremes();
      load_settings(0, 9, 100, 256, 0, 1, 64);
      run_frame(5, 5, -1);
      load_settings(12, 0, 200, 400, 1, 1, 200);
      run_frame(5, 5, -1);
   endtask

   // Random settings and random frames, all of small sizes.
   task automatic test_random_frames();
      int start_count;
      bit held;
      start_count = items_sent;
      held = 1'b0;
      while (items_sent - start_count < 480) begin
         load_settings($urandom_range(1, 9), $urandom_range(1, 7),
                       ($urandom_range(5) == 0) ? 256 : $urandom_range(511),
                       ($urandom_range(5) == 0) ? 511 : $urandom_range(511),
                       $urandom_range(1), $urandom_range(1),
                       ($urandom_range(5) == 0) ? 256 : $urandom_range(256));
         if (items_sent - start_count > 380) calm = 1'b1;
         run_frame($urandom_range(10), $urandom_range(20), held ? -1 : 10);
         held = 1'b1;
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= 1'b0;
      req_in_blue <= 8'd0;
      req_in_green <= 8'd0;
      req_in_red <= 8'd0;
      csr_we <= 1'b0;
      csr_index <= csg_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      mismatches = 0;
      items_sent = 0;
      calm = 1'b0;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      width_reg = 640;
      height_reg = 480;
      keep_reg = 179;
      flicker_reg = 256;
      stripe_en_reg = 0;
      stripe_shift_reg = 0;
      glow_reg = 64;
      for (int i = 0; i < csg_pkg::MEM_DEPTH; i++) ring_pixels[i] = 24'h0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_scanline_saturation();
      test_size_extremes();
      test_random_frames();

      drain_pixels();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
